// ===== rtl/pema_pkg.sv =====
package pema_pkg;

	localparam int SAMPLE_W   = 32;
	localparam int TIME_W     = 32;
	localparam int WIN_W      = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [WIN_W-1:0] WINDOW_RESET = 5'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_FRAMES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_TIME    = 1'b1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [TIME_W-1:0] time_val_t;

endpackage

// ===== rtl/per_element_moving_average.sv =====
// Flow: an accepted stored element issues one read per older frame on the single memory port,
// sums the registered read data, divides in DIV_STEPS steps (9 at the default sizes) on the
// 4-bit-per-cycle divider and waits in ST_OUT until the output register is free; a discarded
// element goes straight to ST_OUT and a zero-length start is taken without a result.
// A new element is taken only in ST_IDLE, after the last one has been loaded for output.
// Reset: arst_n sets control state, configuration and counters to their reset values at once;
// the datapath registers and the history memory are not reset, only entries of held frames are ever read.
module per_element_moving_average #(
	parameter int MAX_FRAMES   = 16,
	parameter int MAX_ELEMENTS = 1024,
	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1),
	localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pema_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pema_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  pema_pkg::sample_t                sample,
	input  logic [CNT_W-1:0]                 element_count,
	input  pema_pkg::time_val_t              frame_time,
	output logic                             out_valid,
	input  logic                             out_ready,
	output pema_pkg::sample_t                average,
	output logic [IDX_W-1:0]                 element_index,
	output logic                             last_of_frame
);
	import pema_pkg::*;

	localparam int FH_W      = $clog2(MAX_FRAMES + 1);
	localparam int SLOT_W    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int SUM_W     = SAMPLE_W + $clog2(MAX_FRAMES);
	localparam int DIV_W     = ((SUM_W + 3) / 4) * 4;
	localparam int DIV_STEPS = DIV_W / 4;
	localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SUM  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]          state_q;
	logic [WIN_W-1:0]    window_q;
	time_val_t           start_time_q;
	logic [FH_W-1:0]     held_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [IDX_W-1:0]    pos_q;
	logic [CNT_W-1:0]    stored_len_q;
	time_val_t           prev_time_q;
	logic                disc_q;
	logic [FH_W-1:0]     issue_k_q;
	logic                rd_pend_s1;
	logic [STEP_W-1:0]   step_q;
	logic                out_valid_q;

	logic [SLOT_W-1:0]   rd_slot_q;
	logic [IDX_W-1:0]    item_pos_q;
	logic                item_last_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                neg_q;
	logic [DIV_W-1:0]    dvd_q;
	logic [FH_W-1:0]     rem_q;
	sample_t             res_q;
	sample_t             avg_q;
	logic [IDX_W-1:0]    idx_q;
	logic                last_q;

	logic [SAMPLE_W-1:0] hist_mem [MAX_FRAMES][MAX_ELEMENTS];
	logic [SAMPLE_W-1:0] rd_data_s1;

	logic                accept;
	logic                frame_start;
	logic                drop;
	logic                late;
	logic [CNT_W-1:0]    len_in;
	logic [FH_W:0]       win_eff;
	logic [FH_W-1:0]     held_base;
	logic [FH_W:0]       held_plus;
	logic [FH_W-1:0]     held_new;
	logic [SLOT_W-1:0]   slot_inc;
	logic                cur_disc;
	logic [FH_W-1:0]     cur_held;
	logic [SLOT_W-1:0]   cur_slot;
	logic [SLOT_W-1:0]   cur_slot_dec;
	logic [CNT_W-1:0]    cur_len;
	logic                is_last;
	logic [IDX_W-1:0]    pos_next;
	logic                active;
	logic                mem_re;
	logic [SLOT_W-1:0]   rd_slot_dec;
	logic [SUM_W-1:0]    sum_mag;
	logic [FH_W:0]       div_r;
	logic [FH_W-1:0]     div_rem;
	logic [DIV_W-1:0]    div_d;
	logic [DIV_W-1:0]    div_q_signed;
	logic                out_load;

	assign in_ready    = (state_q == ST_IDLE);
	assign accept      = in_valid && in_ready;
	assign frame_start = (pos_q == '0);
	assign drop        = frame_start && (element_count == '0);
	assign len_in      = (32'(element_count) > MAX_ELEMENTS) ? CNT_W'(MAX_ELEMENTS)
	                                                         : element_count;
	assign late        = (frame_time < prev_time_q) || (frame_time < start_time_q);

	assign win_eff   = (window_q == '0) ? (FH_W+1)'(1)
	                 : (32'(window_q) >= MAX_FRAMES) ? (FH_W+1)'(MAX_FRAMES)
	                 : (FH_W+1)'(window_q);
	assign held_base = ((held_q != '0) && (len_in != stored_len_q)) ? '0 : held_q;
	assign held_plus = (FH_W+1)'(held_base) + 1'b1;
	assign held_new  = (held_plus > win_eff) ? win_eff[FH_W-1:0] : held_plus[FH_W-1:0];
	assign slot_inc  = (slot_q == SLOT_W'(MAX_FRAMES - 1)) ? '0 : slot_q + 1'b1;

	assign cur_disc     = frame_start ? late : disc_q;
	assign cur_held     = frame_start ? (late ? '0 : held_new) : held_q;
	assign cur_slot     = (frame_start && !late) ? slot_inc : slot_q;
	assign cur_slot_dec = (cur_slot == '0) ? SLOT_W'(MAX_FRAMES - 1) : cur_slot - 1'b1;
	assign cur_len      = frame_start ? len_in : stored_len_q;
	assign is_last      = ((CNT_W+1)'(pos_q) + 1'b1) == (CNT_W+1)'(cur_len);
	assign pos_next     = is_last ? '0 : pos_q + 1'b1;
	assign active       = !cur_disc && (cur_held != '0);

	assign mem_re      = (state_q == ST_SUM) && (issue_k_q < held_q);
	assign rd_slot_dec = (rd_slot_q == '0) ? SLOT_W'(MAX_FRAMES - 1) : rd_slot_q - 1'b1;
	assign sum_mag     = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign out_load    = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		div_rem = rem_q;
		div_d   = dvd_q;
		div_r   = '0;
		for (int i = 0; i < 4; i++) begin
			div_r = {div_rem, div_d[DIV_W-1]};
			div_d = {div_d[DIV_W-2:0], 1'b0};
			if (div_r >= {1'b0, held_q}) begin
				div_r    = div_r - {1'b0, held_q};
				div_d[0] = 1'b1;
			end
			div_rem = div_r[FH_W-1:0];
		end
		div_q_signed = neg_q ? -div_d : div_d;
	end

	always_ff @(posedge clk) begin
		if (accept && !drop && active) begin
			hist_mem[cur_slot][pos_q] <= $unsigned(sample);
		end
		if (mem_re) begin
			rd_data_s1 <= hist_mem[rd_slot_q][item_pos_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			window_q     <= WINDOW_RESET;
			start_time_q <= '0;
			held_q       <= '0;
			slot_q       <= '0;
			pos_q        <= '0;
			stored_len_q <= '0;
			prev_time_q  <= '0;
			disc_q       <= 1'b0;
			issue_k_q    <= '0;
			rd_pend_s1   <= 1'b0;
			step_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_WINDOW_FRAMES: window_q     <= cfg_data[WIN_W-1:0];
					CFG_START_TIME:    start_time_q <= cfg_data[TIME_W-1:0];
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			rd_pend_s1 <= mem_re;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && !drop) begin
						disc_q       <= cur_disc;
						held_q       <= cur_held;
						slot_q       <= cur_slot;
						stored_len_q <= cur_len;
						pos_q        <= pos_next;
						if (frame_start) begin
							prev_time_q <= frame_time;
						end
						issue_k_q <= FH_W'(1);
						state_q   <= active ? ST_SUM : ST_OUT;
					end
				end
				ST_SUM: begin
					if (mem_re) begin
						issue_k_q <= issue_k_q + 1'b1;
					end else if (!rd_pend_s1) begin
						step_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				item_pos_q  <= pos_q;
				item_last_q <= is_last;
				rd_slot_q   <= cur_slot_dec;
				sum_q       <= SUM_W'(sample);
				res_q       <= '0;
			end
			ST_SUM: begin
				if (mem_re) begin
					rd_slot_q <= rd_slot_dec;
				end
				if (rd_pend_s1) begin
					sum_q <= sum_q + SUM_W'($signed(rd_data_s1));
				end
				neg_q <= sum_q[SUM_W-1];
				dvd_q <= DIV_W'(sum_mag);
				rem_q <= '0;
			end
			ST_DIV: begin
				dvd_q <= div_d;
				rem_q <= div_rem;
				res_q <= $signed(div_q_signed[SAMPLE_W-1:0]);
			end
			ST_OUT: begin
				if (out_load) begin
					avg_q  <= res_q;
					idx_q  <= item_pos_q;
					last_q <= item_last_q;
				end
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign average       = avg_q;
	assign element_index = idx_q;
	assign last_of_frame = last_q;

endmodule

// ===== rtl/pema_checker.sv =====
module pema_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input pema_pkg::sample_t average,
	input logic              last_of_frame
);
	import pema_pkg::*;

	// hold a stalled result transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(average) && $stable(last_of_frame))
		else $error("stalled result changed");

	// an accepted transaction never yields its result on the next edge
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared one cycle after acceptance");

	// a new result leaves the block ready again, after a busy cycle
	a_rise_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready && !$past(in_ready))
		else $error("result launch out of step with input readiness");

endmodule

bind per_element_moving_average pema_checker u_pema_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.average       (average),
	.last_of_frame (last_of_frame)
);

// ===== tb/sv/moving_average_checker.sv =====
module moving_average_checker #(
	parameter int MAX_FRAMES   = 16,
	parameter int MAX_ELEMENTS = 1024,
	parameter int CNT_W        = 11,
	parameter int IDX_W        = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pema_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pema_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  pema_pkg::sample_t               sample,
	input  logic [CNT_W-1:0]                element_count,
	input  pema_pkg::time_val_t             frame_time,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  pema_pkg::sample_t               average,
	input  logic [IDX_W-1:0]                element_index,
	input  logic                            last_of_frame,
	output int                              mismatches,
	output int                              waiting,
	output int                              averages_checked,
	output int                              frames_stored,
	output int                              frames_dropped
);

	typedef struct packed {
		pema_pkg::sample_t mean;
		logic [IDX_W-1:0]  index;
		logic              last;
	} mean_result_t;

	mean_result_t expected_means[$];

	pema_pkg::sample_t frame_hist [MAX_FRAMES][MAX_ELEMENTS];

	int unsigned                  held_frames;
	int unsigned                  newest_slot;
	int unsigned                  elem_pos;
	int unsigned                  frame_len;
	pema_pkg::time_val_t          last_time;
	pema_pkg::time_val_t          start_time;
	logic [pema_pkg::WIN_W-1:0]   window_reg;
	logic                         dropping;

	function automatic int unsigned window_limit(input logic [pema_pkg::WIN_W-1:0] w);
		if (w == 0)
			return 1;
		if (w > MAX_FRAMES)
			return MAX_FRAMES;
		return 32'(w);
	endfunction

	task automatic predict_mean(input pema_pkg::sample_t s, input logic [CNT_W-1:0] cnt,
			input pema_pkg::time_val_t t);
		int unsigned  len;
		int unsigned  slot;
		int unsigned  k;
		longint       acc;
		longint       quot;
		mean_result_t r;
		if (elem_pos == 0) begin
			if (cnt == 0)
				return;
			len = (cnt > MAX_ELEMENTS) ? MAX_ELEMENTS : cnt;
			if (t < last_time || t < start_time) begin
				dropping = 1'b1;
				held_frames = 0;
				frames_dropped++;
			end else begin
				dropping = 1'b0;
				if (held_frames > 0 && len != frame_len)
					held_frames = 0;
				held_frames = held_frames + 1;
				if (held_frames > window_limit(window_reg))
					held_frames = window_limit(window_reg);
				newest_slot = (newest_slot + 1) % MAX_FRAMES;
				frames_stored++;
			end
			last_time = t;
			frame_len = len;
		end
		r.mean = '0;
		if (!dropping && held_frames > 0) begin
			frame_hist[newest_slot][elem_pos] = s;
			acc = 0;
			for (k = 0; k < held_frames; k++) begin
				slot = (newest_slot + MAX_FRAMES - k) % MAX_FRAMES;
				acc += longint'(frame_hist[slot][elem_pos]);
			end
			quot = acc / longint'(held_frames);
			r.mean = quot[31:0];
		end
		r.index = IDX_W'(elem_pos);
		r.last = (elem_pos + 1 == frame_len);
		expected_means.push_back(r);
		elem_pos = (elem_pos + 1 >= frame_len) ? 0 : elem_pos + 1;
	endtask

	task automatic check_mean();
		mean_result_t want;
		if (expected_means.size() == 0) begin
			if (mismatches < 10)
				$display("unexpected transaction: average %h index %0d last %b",
					average, element_index, last_of_frame);
			mismatches++;
		end else begin
			want = expected_means.pop_front();
			averages_checked++;
			if (want.mean !== average || want.index !== element_index ||
					want.last !== last_of_frame) begin
				if (mismatches < 10)
					$display("mismatch: average %h/%h index %0d/%0d last %b/%b (expected/actual)",
						want.mean, average, want.index, element_index, want.last, last_of_frame);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_means.delete();
			held_frames = 0;
			newest_slot = 0;
			elem_pos = 0;
			frame_len = 0;
			last_time = '0;
			start_time = '0;
			window_reg = pema_pkg::WINDOW_RESET;
			dropping = 1'b0;
			mismatches = 0;
			waiting = 0;
			averages_checked = 0;
			frames_stored = 0;
			frames_dropped = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == pema_pkg::CFG_WINDOW_FRAMES)
					window_reg = cfg_data[pema_pkg::WIN_W-1:0];
				else if (cfg_index == pema_pkg::CFG_START_TIME)
					start_time = cfg_data;
			end
			if (in_valid && in_ready)
				predict_mean(sample, element_count, frame_time);
			if (out_valid && out_ready)
				check_mean();
			waiting = expected_means.size();
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;

	localparam int CNT_W         = 11;
	localparam int IDX_W         = 10;
	localparam int SETTLE_CYCLES = 40;
	localparam int STALL_LIMIT   = 3000;
	localparam int HOLD_CYCLES   = 600;
	localparam int HOLD_AFTER    = 300;
	localparam int TOTAL_ITEMS   = 1950;
	localparam int PHASE_ITEMS   = 90;

	logic                            clk;
	logic                            arst_n = 1'b0;
	logic                            cfg_we = 1'b0;
	logic [pema_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [pema_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	pema_pkg::sample_t               sample = '0;
	logic [CNT_W-1:0]                element_count = '0;
	pema_pkg::time_val_t             frame_time = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	pema_pkg::sample_t               average;
	logic [IDX_W-1:0]                element_index;
	logic                            last_of_frame;

	int                              mismatches;
	int                              waiting;
	int                              averages_checked;
	int                              frames_stored;
	int                              frames_dropped;

	int unsigned                     sent_items = 0;
	int unsigned                     taken = 0;
	int unsigned                     idle_cycles = 0;
	logic                            send_quiet = 1'b0;
	logic                            take_quiet = 1'b0;
	pema_pkg::time_val_t             now_t = '0;

	per_element_moving_average dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample        (sample),
		.element_count (element_count),
		.frame_time    (frame_time),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.average       (average),
		.element_index (element_index),
		.last_of_frame (last_of_frame)
	);

	moving_average_checker #(
		.CNT_W (CNT_W),
		.IDX_W (IDX_W)
	) checker_i (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.sample           (sample),
		.element_count    (element_count),
		.frame_time       (frame_time),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.average          (average),
		.element_index    (element_index),
		.last_of_frame    (last_of_frame),
		.mismatches       (mismatches),
		.waiting          (waiting),
		.averages_checked (averages_checked),
		.frames_stored    (frames_stored),
		.frames_dropped   (frames_dropped)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int unsigned draw_gap(input logic quiet);
		return quiet ? 0 : $urandom_range(0, 18);
	endfunction

	function automatic pema_pkg::sample_t draw_sample();
		case ($urandom_range(0, 7))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return '0;
			3: return 32'($signed($urandom_range(0, 200)) - 100);
			default: return $urandom;
		endcase
	endfunction

	function automatic pema_pkg::time_val_t next_time();
		int unsigned step;
		step = $urandom_range(0, 500);
		case ($urandom_range(0, 19))
			0: now_t = $urandom;
			1: now_t = now_t - $urandom_range(1, 500);
			2: ;
			default: now_t = (now_t > 32'hFFFF_FFFF - step) ? 32'hFFFF_FFFF : now_t + step;
		endcase
		return now_t;
	endfunction

	task automatic send_item(input pema_pkg::sample_t s, input logic [CNT_W-1:0] cnt,
			input pema_pkg::time_val_t t);
		int unsigned gap;
		if ($urandom_range(0, 59) == 0)
			send_quiet = ~send_quiet;
		gap = draw_gap(send_quiet);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		element_count <= cnt;
		frame_time <= t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_frame(input logic [CNT_W-1:0] cnt, input pema_pkg::time_val_t t);
		int unsigned len;
		int unsigned i;
		len = (cnt > 1024) ? 1024 : cnt;
		if (len == 0) begin
			send_item(draw_sample(), cnt, t);
			return;
		end
		for (i = 0; i < len; i++) begin
			if (i != 0 && $urandom_range(0, 3) == 0)
				send_item(draw_sample(), CNT_W'($urandom), $urandom);
			else
				send_item(draw_sample(), cnt, t);
			sent_items++;
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (waiting != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_config(input logic [pema_pkg::WIN_W-1:0] w, input pema_pkg::time_val_t st);
		cfg_we <= 1'b1;
		cfg_index <= pema_pkg::CFG_WINDOW_FRAMES;
		cfg_data <= pema_pkg::CFG_DATA_W'(w);
		@(negedge clk);
		cfg_index <= pema_pkg::CFG_START_TIME;
		cfg_data <= st;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : result_sink
		int unsigned gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (taken == HOLD_AFTER) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if ($urandom_range(0, 59) == 0)
				take_quiet = ~take_quiet;
			gap = draw_gap(take_quiet);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			taken++;
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int unsigned phase;
		int unsigned phase_start;
		int unsigned cur_len;
		logic [pema_pkg::WIN_W-1:0] w;
		pema_pkg::time_val_t st;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_item(32'sh7FFF_FFFF, 11'd1, 32'd0);
		send_item(32'sh7FFF_FFFF, 11'd1, 32'd0);
		send_item(32'sh7FFF_FFFF, 11'd1, 32'd5);
		send_item(32'sh8000_0000, 11'd1, 32'd6);
		send_item(32'sh0000_1234, 11'd0, 32'd7);
		send_item(32'sh8000_0000, 11'd2, 32'd7);
		send_item(-32'sd1, 11'd2, 32'd7);
		send_item(32'sd5, 11'd2, 32'd3);
		send_item(32'sd6, 11'd2, 32'd3);
		send_item(-32'sd3, 11'd2, 32'd10);
		send_item(32'sd0, 11'd2, 32'd10);
		send_item(-32'sd2, 11'd2, 32'd11);
		send_item(32'sd1, 11'd2, 32'd11);
		send_item(32'sh0001_0000, 11'd3, 32'd20);
		send_item(32'sh0001_8000, 11'd0, 32'd0);
		send_item(-32'sh8000, 11'd2047, 32'hFFFF_FFFF);
		now_t = 32'd20;
		settle();

		cur_len = 4;
		phase = 0;
		while (sent_items < TOTAL_ITEMS || phase < 10) begin
			case (phase % 10)
				0: begin w = 5'd1; st = '0; end
				1: begin w = 5'd16; st = '0; end
				2: begin
					w = 5'd0;
					st = (now_t > 32'hFFFF_FFFF - 2000) ? 32'hFFFF_FFFF : now_t + 2000;
				end
				3: begin w = 5'd31; st = '0; end
				4: begin w = 5'd16; st = '0; end
				5: begin w = 5'd17; st = 32'hFFFF_FFFF; now_t = 32'hFFFF_FFF0; end
				6: begin
					w = 5'($urandom_range(1, 16));
					st = $urandom;
					now_t = st - 100;
				end
				7: begin w = 5'd2; st = '0; now_t = '0; end
				8: begin w = 5'd5; st = $urandom_range(0, 5000); end
				default: begin w = 5'($urandom_range(0, 31)); st = '0; end
			endcase
			set_config(w, st);
			phase_start = sent_items;
			if (phase == 4)
				send_frame(CNT_W'($urandom_range(1024, 2047)), now_t);
			while (sent_items - phase_start < PHASE_ITEMS) begin
				if ($urandom_range(0, 29) == 0)
					send_frame('0, next_time());
				if ($urandom_range(0, 6) == 0)
					cur_len = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 32 : 6);
				send_frame(CNT_W'(cur_len), next_time());
			end
			settle();
			phase++;
		end

		$display("Checked %0d averages over %0d stored and %0d dropped frames in %0d phases,",
			averages_checked, frames_stored, frames_dropped, phase);
		$display("with windows from 0 to 31, moving start times and a long output stall.");
		if (mismatches == 0 && waiting == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/pema_pkg.sv
rtl/per_element_moving_average.sv
rtl/pema_checker.sv
tb/sv/moving_average_checker.sv
tb/sv/tb_top.sv
